### sv/sol_pkg.sv
// ----------------------------------------------------------------------------
// self-organizing list package
// shared widths, operation / status / policy codes, register map and the cell control bundle
// ----------------------------------------------------------------------------
`default_nettype none

package sol_pkg;

    localparam int KEY_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 4;
    localparam int ENTRIES_W  = 5;
    localparam int POLICY_W   = 2;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // operation carried in tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // result status
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // reorder policy
    localparam logic [POLICY_W-1:0] POL_MTF       = 2'd0;
    localparam logic [POLICY_W-1:0] POL_TRANSPOSE = 2'd1;
    localparam logic [POLICY_W-1:0] POL_COUNT     = 2'd2;

    // register map
    localparam logic [PADDR_W-1:0] REG_POLICY_ADDR = 3'd0;

    // per-cell update command
    typedef struct packed {
        logic load;        // take the broadcast entry
        logic take_left;   // take the entry of the cell one place toward the head
        logic take_right;  // take the entry of the cell one place toward the tail
    } t_cell_ctrl;

endpackage

`default_nettype wire

### sv/sol_cell.sv
// ----------------------------------------------------------------------------
// self-organizing list cell
// holds one key and its hit count, compares against the broadcast key and count
// ----------------------------------------------------------------------------
`default_nettype none

module sol_cell
    import sol_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                    i_clk,
    input  wire  t_cell_ctrl       i_ctrl,
    input  wire                    i_valid,
    input  wire  [KEY_W-1:0]       i_cmp_key,
    input  wire  [COUNT_WIDTH-1:0] i_thresh,
    input  wire  [KEY_W-1:0]       i_load_key,
    input  wire  [COUNT_WIDTH-1:0] i_load_count,
    input  wire  [KEY_W-1:0]       i_left_key,
    input  wire  [COUNT_WIDTH-1:0] i_left_count,
    input  wire  [KEY_W-1:0]       i_right_key,
    input  wire  [COUNT_WIDTH-1:0] i_right_count,
    output logic [KEY_W-1:0]       o_key,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic                   o_match,
    output logic                   o_qual
);

    logic [KEY_W-1:0]       r_key;
    logic [COUNT_WIDTH-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_key   <= i_load_key;
            r_count <= i_load_count;
        end else if (i_ctrl.take_left) begin
            r_key   <= i_left_key;
            r_count <= i_left_count;
        end else if (i_ctrl.take_right) begin
            r_key   <= i_right_key;
            r_count <= i_right_count;
        end
    end

    assign o_key   = r_key;
    assign o_count = r_count;
    assign o_match = i_valid && (r_key == i_cmp_key);
    assign o_qual  = i_valid && (r_count <= i_thresh);

endmodule

`default_nettype wire

### sv/self_organizing_list.sv
// ----------------------------------------------------------------------------
// self-organizing list
// ordered key table with move-to-front, transpose and frequency-count reorder
// ----------------------------------------------------------------------------
// an accepted input beat is captured with its first-match vector; the result beat
//   is registered in the reorder state
// no input beat is taken in the reorder state; the key compare across all cells takes
//   the accept cycle, the shift / swap of neighboring cells takes the next one
// a result that is not taken holds off the next input beat; the edge that
//   drains the result may accept the next beat
// reset (synchronous, active low) empties the table, sets policy to
//   move-to-front and drops the output beat; cell contents are not cleared
`default_nettype none

module self_organizing_list
    import sol_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input stream
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [KEY_W-1:0]     s_axis_tdata,   // [31:0] key
    input  wire                  s_axis_tuser,   // [0] operation
    // result stream
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [1:0] status, [5:2] found_position,
                                                 // [10:6] entry_count, [15:11] zero
    // configuration
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [PADDR_W-1:0]   paddr,
    input  wire  [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int N  = TABLE_DEPTH;
    localparam int OW = $clog2(TABLE_DEPTH + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    // control state
    t_state                r_state, n_state;
    logic [OW-1:0]         r_occ, n_occ;
    logic [POLICY_W-1:0]   r_policy;
    logic                  r_ovalid, n_ovalid;

    // item held between the compare and the reorder cycle
    logic                  r_op;
    logic [KEY_W-1:0]      r_key;
    logic [N-1:0]          r_hit;      // one-hot first match, zero on miss

    // result register
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [ENTRIES_W-1:0]  r_entries, n_entries;

    // cell row
    logic [KEY_W-1:0]       w_key [N];
    logic [COUNT_WIDTH-1:0] w_cnt [N];
    t_cell_ctrl             w_ctrl [N];
    logic [N-1:0]           w_valid, w_match, w_qual, w_first_hit;

    // reorder decode
    logic                   w_in_acc, w_upd, w_full, w_any_hit;
    logic                   w_ins_go, w_move;
    logic [COUNT_WIDTH-1:0] w_hit_cnt, w_new_cnt, w_load_cnt;
    logic [POS_W-1:0]       w_pos;
    logic [N-1:0]           w_cand, w_first_q, w_blw_p, w_abv_p;
    logic [N-1:0]           w_tgt, w_tgt_cnt, w_blw_t, w_abv_t;
    logic                   w_no_q;

    // ------------------------------------------------------------------------
    // configuration port: single policy register, no wait states
    // ------------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_MTF;
        end else if (psel && penable && pwrite && pready && (paddr == REG_POLICY_ADDR)) begin
            r_policy <= pwdata[POLICY_W-1:0];
        end
    end

    assign prdata = (paddr == REG_POLICY_ADDR) ? PDATA_W'(r_policy) : '0;

    // ------------------------------------------------------------------------
    // handshake and sequencing
    // a beat is taken only when the result register will be free by the
    // reorder cycle: empty now, or drained at this same edge
    // ------------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_upd         = (r_state == S_UPD);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_ovalid <= n_ovalid;
        end
    end

    // capture the beat together with the first-match vector of the cells
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op  <= s_axis_tuser;
            r_key <= s_axis_tdata;
            r_hit <= w_first_hit;
        end
    end

    // ------------------------------------------------------------------------
    // hit entry: position, count and saturated new count
    // ------------------------------------------------------------------------
    assign w_any_hit = |r_hit;
    assign w_full    = (r_occ == OW'(TABLE_DEPTH));

    always_comb begin
        w_hit_cnt = '0;
        w_pos     = '0;
        for (int i = 0; i < N; i++) begin
            w_hit_cnt = w_hit_cnt | (w_cnt[i] & {COUNT_WIDTH{r_hit[i]}});
            w_pos     = w_pos | (POS_W'(i) & {POS_W{r_hit[i]}});
        end
    end

    assign w_new_cnt = (w_hit_cnt == COUNT_MAX) ? w_hit_cnt : w_hit_cnt + 1'b1;

    assign w_ins_go = w_upd && (r_op == OP_INSERT) && !w_full;
    assign w_move   = w_upd && (r_op == OP_SEARCH) && w_any_hit;

    assign w_load_cnt = (r_op == OP_INSERT)       ? '0        :
                        (r_policy == POL_COUNT)   ? w_new_cnt : w_hit_cnt;

    // ------------------------------------------------------------------------
    // target place of the hit entry
    // count mode: first other valid cell whose count does not exceed the new
    // count; a cell behind the hit entry maps one place toward the head since
    // the entry itself has been taken out; none found keeps the old place
    // ------------------------------------------------------------------------
    assign w_cand = w_qual & ~r_hit;
    assign w_no_q = ~|w_cand;

    assign w_tgt_cnt = (w_first_q & w_blw_p)
                     | ((w_first_q >> 1) & ~w_blw_p)
                     | ({N{w_no_q}} & r_hit);

    always_comb begin
        case (r_policy)
            POL_MTF:       w_tgt = N'(1);
            POL_TRANSPOSE: w_tgt = (r_hit >> 1) | (r_hit & N'(1));
            POL_COUNT:     w_tgt = w_tgt_cnt;
            default:       w_tgt = '0;  // unused code: find and report only
        endcase
    end

    // ------------------------------------------------------------------------
    // cell row: each cell compares, then loads, shifts or holds
    // toward the head of the hit entry (target before it): cells in
    // (target, hit] take from the left; target behind it: cells in
    // [hit, target) take from the right; an insert shifts the whole row
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < N; g++) begin : g_cell
        localparam logic [N-1:0] LO = (N'(1) << g) - N'(1);
        localparam logic [N-1:0] HI = ~(LO | (N'(1) << g));

        logic [KEY_W-1:0]       w_lkey, w_rkey;
        logic [COUNT_WIDTH-1:0] w_lcnt, w_rcnt;

        assign w_valid[g]     = (OW'(g) < r_occ);
        assign w_first_hit[g] = w_match[g] & ~|(w_match & LO);
        assign w_first_q[g]   = w_cand[g] & ~|(w_cand & LO);
        assign w_blw_p[g]     = |(r_hit & HI);
        assign w_abv_p[g]     = |(r_hit & LO);
        assign w_blw_t[g]     = |(w_tgt & HI);
        assign w_abv_t[g]     = |(w_tgt & LO);

        assign w_ctrl[g].load       = w_ins_go ? (g == 0) : (w_move & w_tgt[g]);
        assign w_ctrl[g].take_left  = w_ins_go ? (g != 0)
                                               : (w_move & w_abv_t[g] & ~w_abv_p[g]);
        assign w_ctrl[g].take_right = !w_ins_go && w_move && !w_blw_p[g] && w_blw_t[g];

        if (g == 0) begin : g_head
            assign w_lkey = r_key;
            assign w_lcnt = w_load_cnt;
        end else begin : g_mid_l
            assign w_lkey = w_key[g-1];
            assign w_lcnt = w_cnt[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign w_rkey = w_key[g];
            assign w_rcnt = w_cnt[g];
        end else begin : g_mid_r
            assign w_rkey = w_key[g+1];
            assign w_rcnt = w_cnt[g+1];
        end

        sol_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl[g]),
            .i_valid       (w_valid[g]),
            .i_cmp_key     (s_axis_tdata),
            .i_thresh      (w_new_cnt),
            .i_load_key    (r_key),
            .i_load_count  (w_load_cnt),
            .i_left_key    (w_lkey),
            .i_left_count  (w_lcnt),
            .i_right_key   (w_rkey),
            .i_right_count (w_rcnt),
            .o_key         (w_key[g]),
            .o_count       (w_cnt[g]),
            .o_match       (w_match[g]),
            .o_qual        (w_qual[g])
        );
    end

    // ------------------------------------------------------------------------
    // occupancy and result beat
    // ------------------------------------------------------------------------
    assign n_occ = w_ins_go ? r_occ + 1'b1 : r_occ;

    always_comb begin
        if (r_op == OP_INSERT) begin
            n_status = w_full ? ST_FULL : ST_DONE;
            n_pos    = '0;
        end else begin
            n_status = w_any_hit ? ST_DONE : ST_MISS;
            n_pos    = w_any_hit ? w_pos : '0;
        end
        n_entries = ENTRIES_W'(n_occ);
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (w_upd) begin
            n_ovalid = 1'b1;
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_status  <= n_status;
            r_pos     <= n_pos;
            r_entries <= n_entries;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_entries, r_pos, r_status};

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(TABLE_DEPTH))
        else $error("occupancy beyond table depth");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(r_hit))
        else $error("more than one first-match cell");

    a_result_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
        else $error("no result beat two cycles after accept");

endmodule

`default_nettype wire
